// ===== sv/rbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and types for the ray/box slab intersect core.
// Depends on nothing; every other file imports it.
package rbs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int NUM_W      = DIFF_W + FRAC_BITS;
  localparam int DEN_W      = COORD_W;
  localparam int DIV_STAGES = NUM_W;
  localparam int T_W        = NUM_W + 2;
  localparam int HI_W       = NUM_W - COORD_W;
  localparam int PLO_W      = 2 * COORD_W;
  localparam int PHI_W      = COORD_W + HI_W;
  localparam int MAG_W      = PLO_W - FRAC_BITS + 1;
  localparam int CAP_W      = 35;
  localparam int PT_W       = CAP_W + 2;
  localparam int DIST_W     = 31;
  localparam int LATENCY    = DIV_STAGES + 8;

  localparam logic signed [T_W-1:0] T_POS_INF = {2'b01, {NUM_W{1'b0}}};
  localparam logic signed [T_W-1:0] T_NEG_INF = {2'b11, {NUM_W{1'b0}}};
  localparam logic [CAP_W-1:0] PROD_CAP = {1'b1, {(CAP_W-1){1'b0}}};
  localparam logic [PHI_W-1:0] HI_LIMIT = PHI_W'(1) << (FRAC_BITS + 2);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [1:0] NRM_ZERO = 2'sb00;
  localparam logic signed [1:0] NRM_POS  = 2'sb01;
  localparam logic signed [1:0] NRM_NEG  = 2'sb11;

  // Per-item data carried alongside the divider pipeline.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] org;
    logic [2:0][COORD_W-1:0] dir;
    logic [2:0]              par;
    logic [2:0]              neg_lo;
    logic [2:0]              neg_hi;
    logic                    par_miss;
  } sb_t;

  // Running slab interval.
  typedef struct packed {
    logic signed [T_W-1:0] tmin;
    logic signed [T_W-1:0] tmax;
    logic [1:0]            axis;
    logic                  miss;
  } acc_t;

endpackage

// ===== sv/ray_box_slab_intersect_core.sv =====
`timescale 1ns / 1ps
// Ray versus axis-aligned box slab test, Q16.16, fully pipelined.
// Throughput one item per cycle unless a held result stalls the pipe.
// The six slab divisions run in 49-stage bit-per-stage dividers, which set the depth.
// A stall at the output while a result is valid freezes the whole pipe; in_stall is raised in that cycle.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
module ray_box_slab_intersect_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rbs_pkg::COORD_W-1:0]  origin_x,
  input  logic signed [rbs_pkg::COORD_W-1:0]  origin_y,
  input  logic signed [rbs_pkg::COORD_W-1:0]  origin_z,
  input  logic signed [rbs_pkg::COORD_W-1:0]  dir_x,
  input  logic signed [rbs_pkg::COORD_W-1:0]  dir_y,
  input  logic signed [rbs_pkg::COORD_W-1:0]  dir_z,
  input  logic signed [rbs_pkg::COORD_W-1:0]  box_min_x,
  input  logic signed [rbs_pkg::COORD_W-1:0]  box_min_y,
  input  logic signed [rbs_pkg::COORD_W-1:0]  box_min_z,
  input  logic signed [rbs_pkg::COORD_W-1:0]  box_max_x,
  input  logic signed [rbs_pkg::COORD_W-1:0]  box_max_y,
  input  logic signed [rbs_pkg::COORD_W-1:0]  box_max_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit,
  output logic [rbs_pkg::DIST_W-1:0]          distance,
  output logic signed [rbs_pkg::COORD_W-1:0]  point_x,
  output logic signed [rbs_pkg::COORD_W-1:0]  point_y,
  output logic signed [rbs_pkg::COORD_W-1:0]  point_z,
  output logic signed [1:0]                   normal_x,
  output logic signed [1:0]                   normal_y,
  output logic signed [1:0]                   normal_z
);
  import rbs_pkg::*;

  // Global advance: the pipe moves unless a finished result is held.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- entry: slab numerators and divisor magnitudes ----------------
  logic [2:0][COORD_W-1:0] in_org, in_dir, in_lo, in_hi;
  assign in_org = {origin_z, origin_y, origin_x};
  assign in_dir = {dir_z, dir_y, dir_x};
  assign in_lo  = {box_min_z, box_min_y, box_min_x};
  assign in_hi  = {box_max_z, box_max_y, box_max_x};

  sb_t                     sb_in;
  logic [2:0][NUM_W-1:0]   num_lo, num_hi;
  logic [2:0][DEN_W-1:0]   den_abs;

  always_comb begin
    logic signed [DIFF_W-1:0] d_lo, d_hi, o, lo, hi;
    logic [DIFF_W-1:0]        m_lo, m_hi;
    sb_in = '0;
    for (int i = 0; i < 3; i++) begin
      o    = {in_org[i][COORD_W-1], in_org[i]};
      lo   = {in_lo[i][COORD_W-1], in_lo[i]};
      hi   = {in_hi[i][COORD_W-1], in_hi[i]};
      d_lo = lo - o;
      d_hi = hi - o;
      m_lo = d_lo[DIFF_W-1] ? DIFF_W'(-d_lo) : DIFF_W'(d_lo);
      m_hi = d_hi[DIFF_W-1] ? DIFF_W'(-d_hi) : DIFF_W'(d_hi);
      num_lo[i] = {m_lo, {FRAC_BITS{1'b0}}};
      num_hi[i] = {m_hi, {FRAC_BITS{1'b0}}};
      den_abs[i] = in_dir[i][COORD_W-1] ? DEN_W'(-in_dir[i]) : in_dir[i];
      sb_in.org[i]    = in_org[i];
      sb_in.dir[i]    = in_dir[i];
      sb_in.par[i]    = (in_dir[i] == '0);
      sb_in.neg_lo[i] = d_lo[DIFF_W-1] ^ in_dir[i][COORD_W-1];
      sb_in.neg_hi[i] = d_hi[DIFF_W-1] ^ in_dir[i][COORD_W-1];
      // parallel axis with origin outside the slab misses outright
      if (sb_in.par[i] && (($signed(in_org[i]) < $signed(in_lo[i])) ||
                           ($signed(in_org[i]) > $signed(in_hi[i]))))
        sb_in.par_miss = 1'b1;
    end
  end

  // ---------------- divider pipeline ----------------
  logic [2:0][NUM_W-1:0] q_lo, q_hi;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rbs_udiv u_div_lo (.clk(clk), .en(en), .num(num_lo[i]), .den(den_abs[i]), .quo(q_lo[i]));
    rbs_udiv u_div_hi (.clk(clk), .en(en), .num(num_hi[i]), .den(den_abs[i]), .quo(q_hi[i]));
  end

  sb_t  sb [DIV_STAGES];
  logic v_div [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= sb_in;
      for (int k = 1; k < DIV_STAGES; k++) sb[k] <= sb[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) v_div[k] <= 1'b0;
    end else if (en) begin
      v_div[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) v_div[k] <= v_div[k-1];
    end
  end

  // ---------------- signed slab distances ----------------
  logic [2:0][T_W-1:0] t_lo, t_hi;
  sb_t                 sb_e;
  logic                v_e;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t_lo[i] <= sb[DIV_STAGES-1].neg_lo[i] ? T_W'(-{2'b00, q_lo[i]}) : {2'b00, q_lo[i]};
        t_hi[i] <= sb[DIV_STAGES-1].neg_hi[i] ? T_W'(-{2'b00, q_hi[i]}) : {2'b00, q_hi[i]};
      end
      sb_e <= sb[DIV_STAGES-1];
    end
  end

  // ---------------- order near/far per axis ----------------
  logic [2:0][T_W-1:0] near_f, far_f;
  sb_t                 sb_f;
  logic                v_f;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if ($signed(t_lo[i]) > $signed(t_hi[i])) begin
          near_f[i] <= t_hi[i];
          far_f[i]  <= t_lo[i];
        end else begin
          near_f[i] <= t_lo[i];
          far_f[i]  <= t_hi[i];
        end
      end
      sb_f <= sb_e;
    end
  end

  // ---------------- narrow the interval, one axis per stage ----------------
  function automatic acc_t narrow(acc_t a, logic signed [T_W-1:0] nr,
                                  logic signed [T_W-1:0] fr, logic par, logic [1:0] ax);
    acc_t r;
    r = a;
    if (!par) begin
      if (nr > r.tmin) begin
        r.tmin = nr;
        r.axis = ax;
      end
      if (fr < r.tmax) r.tmax = fr;
      if (r.tmin > r.tmax) r.miss = 1'b1;
    end
    return r;
  endfunction

  acc_t                acc_g  [3];
  sb_t                 sb_g   [3];
  logic [2:0][T_W-1:0] near_g [3];
  logic [2:0][T_W-1:0] far_g  [3];
  logic                v_g    [3];

  always_ff @(posedge clk) begin
    acc_t init;
    init.tmin = T_NEG_INF;
    init.tmax = T_POS_INF;
    init.axis = AXIS_X;
    init.miss = sb_f.par_miss;
    if (en) begin
      acc_g[0]  <= narrow(init, near_f[0], far_f[0], sb_f.par[0], AXIS_X);
      sb_g[0]   <= sb_f;
      near_g[0] <= near_f;
      far_g[0]  <= far_f;
      acc_g[1]  <= narrow(acc_g[0], near_g[0][1], far_g[0][1], sb_g[0].par[1], AXIS_Y);
      sb_g[1]   <= sb_g[0];
      near_g[1] <= near_g[0];
      far_g[1]  <= far_g[0];
      acc_g[2]  <= narrow(acc_g[1], near_g[1][2], far_g[1][2], sb_g[1].par[2], AXIS_Z);
      sb_g[2]   <= sb_g[1];
      near_g[2] <= near_g[1];
      far_g[2]  <= far_g[1];
    end
  end

  // ---------------- hit decision and partial products ----------------
  logic                    hit_m;
  logic [DIST_W-1:0]       dist_m;
  logic signed [1:0]       nrm_m [3];
  logic [2:0][COORD_W-1:0] org_m;
  logic [2:0]              dneg_m;
  logic [2:0][PLO_W-1:0]   plo_m;
  logic [2:0][PHI_W-1:0]   phi_m;
  logic                    v_m;

  always_ff @(posedge clk) begin
    logic              h;
    logic [NUM_W-1:0]  tu;
    logic [DEN_W-1:0]  ad;
    acc_t              a;
    a  = acc_g[2];
    h  = !a.miss && !a.tmin[T_W-1];
    tu = a.tmin[NUM_W-1:0];
    if (en) begin
      hit_m  <= h;
      dist_m <= (a.tmin > $signed({{(T_W-DIST_W){1'b0}}, DIST_MAX})) ? DIST_MAX
                                                                      : a.tmin[DIST_W-1:0];
      for (int i = 0; i < 3; i++) begin
        ad = sb_g[2].dir[i][COORD_W-1] ? DEN_W'(-sb_g[2].dir[i]) : sb_g[2].dir[i];
        plo_m[i]  <= PLO_W'(ad) * PLO_W'(tu[COORD_W-1:0]);
        phi_m[i]  <= PHI_W'(ad) * PHI_W'(tu[NUM_W-1:COORD_W]);
        org_m[i]  <= sb_g[2].org[i];
        dneg_m[i] <= sb_g[2].dir[i][COORD_W-1];
        if (a.axis == 2'(i))
          nrm_m[i] <= sb_g[2].dir[i][COORD_W-1] ? NRM_POS : NRM_NEG;
        else
          nrm_m[i] <= NRM_ZERO;
      end
    end
  end

  // ---------------- product magnitude, truncated and capped ----------------
  logic                    hit_c;
  logic [DIST_W-1:0]       dist_c;
  logic signed [1:0]       nrm_c [3];
  logic [2:0][COORD_W-1:0] org_c;
  logic [2:0]              dneg_c;
  logic [2:0][CAP_W-1:0]   mag_c;
  logic                    v_c;

  always_ff @(posedge clk) begin
    logic [MAG_W-1:0] sum;
    if (en) begin
      hit_c  <= hit_m;
      dist_c <= dist_m;
      org_c  <= org_m;
      dneg_c <= dneg_m;
      for (int i = 0; i < 3; i++) begin
        nrm_c[i] <= nrm_m[i];
        sum = MAG_W'({phi_m[i][FRAC_BITS+1:0], {(COORD_W-FRAC_BITS){1'b0}}})
            + MAG_W'(plo_m[i][PLO_W-1:FRAC_BITS]);
        if (phi_m[i] >= HI_LIMIT || sum > MAG_W'(PROD_CAP)) mag_c[i] <= PROD_CAP;
        else mag_c[i] <= sum[CAP_W-1:0];
      end
    end
  end

  // ---------------- hit point, saturate, output register ----------------
  logic signed [COORD_W-1:0] pt [3];

  always_comb begin
    logic signed [PT_W-1:0] s, o, m;
    for (int i = 0; i < 3; i++) begin
      o = PT_W'($signed(org_c[i]));
      m = {2'b00, mag_c[i]};
      s = dneg_c[i] ? o - m : o + m;
      if (s > PT_W'($signed({1'b0, {(COORD_W-1){1'b1}}})))
        pt[i] = {1'b0, {(COORD_W-1){1'b1}}};
      else if (s < PT_W'($signed({1'b1, {(COORD_W-1){1'b0}}})))
        pt[i] = {1'b1, {(COORD_W-1){1'b0}}};
      else
        pt[i] = s[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= hit_c;
      distance <= hit_c ? dist_c : '0;
      point_x  <= hit_c ? pt[0] : '0;
      point_y  <= hit_c ? pt[1] : '0;
      point_z  <= hit_c ? pt[2] : '0;
      normal_x <= hit_c ? nrm_c[0] : NRM_ZERO;
      normal_y <= hit_c ? nrm_c[1] : NRM_ZERO;
      normal_z <= hit_c ? nrm_c[2] : NRM_ZERO;
    end
  end

  // Valid bits of the tail stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_e       <= 1'b0;
      v_f       <= 1'b0;
      v_g[0]    <= 1'b0;
      v_g[1]    <= 1'b0;
      v_g[2]    <= 1'b0;
      v_m       <= 1'b0;
      v_c       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_e       <= v_div[DIV_STAGES-1];
      v_f       <= v_e;
      v_g[0]    <= v_f;
      v_g[1]    <= v_g[0];
      v_g[2]    <= v_g[1];
      v_m       <= v_g[2];
      v_c       <= v_m;
      out_valid <= v_c;
    end
  end

  // ---------------- checks ----------------
  a_stall_follows_hold: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not track held result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '0 && point_x == '0 && point_y == '0 &&
                          point_z == '0 && normal_x == NRM_ZERO &&
                          normal_y == NRM_ZERO && normal_z == NRM_ZERO)
    else $error("miss result carries nonzero fields");

  a_one_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> $onehot({normal_x != NRM_ZERO, normal_y != NRM_ZERO,
                                  normal_z != NRM_ZERO}))
    else $error("hit without exactly one normal axis");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== sv/rbs_udiv.sv =====
`timescale 1ns / 1ps
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Depends on rbs_pkg for widths.
module rbs_udiv (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rbs_pkg::NUM_W-1:0] num,
  input  logic [rbs_pkg::DEN_W-1:0] den,
  output logic [rbs_pkg::NUM_W-1:0] quo
);
  import rbs_pkg::*;

  logic [NUM_W-1:0] nq   [DIV_STAGES];
  logic [DEN_W-1:0] rem  [DIV_STAGES];
  logic [DEN_W-1:0] dens [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0] cur_num;
    logic [DEN_W-1:0] cur_rem;
    logic [DEN_W-1:0] cur_den;
    logic [DEN_W:0]   shifted;
    logic             ge;

    if (k == 0) begin : g_first
      assign cur_num = num;
      assign cur_rem = '0;
      assign cur_den = den;
    end else begin : g_next
      assign cur_num = nq[k-1];
      assign cur_rem = rem[k-1];
      assign cur_den = dens[k-1];
    end

    assign shifted = {cur_rem, cur_num[NUM_W-1]};
    assign ge      = shifted >= {1'b0, cur_den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? DEN_W'(shifted - {1'b0, cur_den}) : shifted[DEN_W-1:0];
        nq[k]   <= {cur_num[NUM_W-2:0], ge};
        dens[k] <= cur_den;
      end
    end
  end

  assign quo = nq[DIV_STAGES-1];

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ray_box_slab_intersect_core: directed and random rays.
// Depends on rbs_pkg and the core RTL. A scoreboard class predicts each hit result.

module tb_top;
  import rbs_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One ray/box test: origin, direction, lower and upper corner per axis.
  typedef struct {
    coord_t org [3];
    coord_t dir [3];
    coord_t lo  [3];
    coord_t hi  [3];
  } ray_box_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
    coord_t            point [3];
    logic signed [1:0] normal [3];
  } hit_result_t;

  // Scoreboard: predicts the slab test for each accepted item and
  // checks the results in order.
  class slab_scoreboard;
    hit_result_t pending_hits [$];
    int          errors;

    // Origin plus dir * t, product truncated toward zero, then saturated.
    function automatic coord_t hit_coord(longint o, longint d, longint t);
      bit [63:0] ad, th, tl, ahi, alo, mag;
      longint    s;
      ad  = (d < 0) ? -d : d;
      th  = t >> 32;
      tl  = t & 64'hFFFF_FFFF;
      ahi = ad * th;
      alo = ad * tl;
      if (ahi >= (64'd1 << (FRAC_BITS + 2))) begin
        mag = PROD_CAP;
      end else begin
        mag = (ahi << (32 - FRAC_BITS)) + (alo >> FRAC_BITS);
        if (mag > PROD_CAP) mag = PROD_CAP;
      end
      s = (d < 0) ? o - longint'(mag) : o + longint'(mag);
      if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
      if (s < -64'sh8000_0000) s = -64'sh8000_0000;
      return coord_t'(s);
    endfunction

    function automatic hit_result_t slab_test(ray_box_t r);
      hit_result_t res;
      longint      tmin, tmax, t1, t2, sw, o, d;
      int          axis;
      tmin = -(64'sd1 <<< 60);
      tmax = 64'sd1 <<< 60;
      axis = 0;
      res.hit = 0;
      res.distance = '0;
      for (int i = 0; i < 3; i++) begin
        res.point[i] = '0;
        res.normal[i] = NRM_ZERO;
      end
      for (int i = 0; i < 3; i++) begin
        if (r.dir[i] == 0) begin
          if (r.org[i] < r.lo[i] || r.org[i] > r.hi[i]) return res;
        end else begin
          o  = r.org[i];
          d  = r.dir[i];
          t1 = ((longint'(r.lo[i]) - o) * (64'sd1 <<< FRAC_BITS)) / d;
          t2 = ((longint'(r.hi[i]) - o) * (64'sd1 <<< FRAC_BITS)) / d;
          if (t1 > t2) begin
            sw = t1; t1 = t2; t2 = sw;
          end
          if (t1 > tmin) begin
            tmin = t1; axis = i;
          end
          if (t2 < tmax) tmax = t2;
          if (tmin > tmax) return res;
        end
      end
      if (tmin < 0) return res;
      res.hit = 1;
      res.distance = (tmin > 64'sh7FFF_FFFF) ? DIST_MAX : DIST_W'(tmin);
      for (int i = 0; i < 3; i++) res.point[i] = hit_coord(r.org[i], r.dir[i], tmin);
      res.normal[axis] = (r.dir[axis] > 0) ? NRM_NEG : NRM_POS;
      return res;
    endfunction

    function void note_ray(ray_box_t r);
      pending_hits.push_back(slab_test(r));
    endfunction

    function void field_chk(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(hit_result_t act);
      hit_result_t exp_r;
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending: expected none, actual hit=%b",
                 $time, act.hit);
        return;
      end
      exp_r = pending_hits.pop_front();
      field_chk("hit", exp_r.hit, act.hit);
      field_chk("distance", exp_r.distance, act.distance);
      field_chk("point_x", exp_r.point[0], act.point[0]);
      field_chk("point_y", exp_r.point[1], act.point[1]);
      field_chk("point_z", exp_r.point[2], act.point[2]);
      field_chk("normal_x", exp_r.normal[0], act.normal[0]);
      field_chk("normal_y", exp_r.normal[1], act.normal[1]);
      field_chk("normal_z", exp_r.normal[2], act.normal[2]);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_stall = 0;
  logic in_stall, out_valid, hit;
  logic [DIST_W-1:0] distance;
  coord_t point_x, point_y, point_z;
  logic signed [1:0] normal_x, normal_y, normal_z;
  ray_box_t cur_ray;

  // Sender and receiver idle percentages, and a long output hold-off on request.
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  hold_left = 0;

  slab_scoreboard sb = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  ray_box_slab_intersect_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .origin_x(cur_ray.org[0]), .origin_y(cur_ray.org[1]), .origin_z(cur_ray.org[2]),
    .dir_x(cur_ray.dir[0]), .dir_y(cur_ray.dir[1]), .dir_z(cur_ray.dir[2]),
    .box_min_x(cur_ray.lo[0]), .box_min_y(cur_ray.lo[1]), .box_min_z(cur_ray.lo[2]),
    .box_max_x(cur_ray.hi[0]), .box_max_y(cur_ray.hi[1]), .box_max_z(cur_ray.hi[2]),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .distance(distance),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
  );

  // Watch both handshakes. Values read here are the ones from before this
  // edge's updates, so acceptance matches what the core saw.
  always @(posedge clk) begin
    hit_result_t act;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_ray(cur_ray);
      if (out_valid && !out_stall) begin
        act.hit = hit;
        act.distance = distance;
        act.point[0] = point_x;
        act.point[1] = point_y;
        act.point[2] = point_z;
        act.normal[0] = normal_x;
        act.normal[1] = normal_y;
        act.normal[2] = normal_z;
        sb.check_result(act);
      end
    end
  end

  // Output side: random stalls, or a long hold-off counted down here so the
  // pipe fills and pushes back on the input.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offer one item: idle for a random gap first, then hold it until taken.
  task automatic send_ray(ray_box_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cur_ray  <= r;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom) >>> $urandom_range(31);
  endfunction

  // Mostly well-formed: a box near the origin and a ray aimed at it from
  // outside, sometimes with a parallel axis; the rest is raw noise.
  function automatic ray_box_t rand_ray();
    ray_box_t r;
    int       kind;
    coord_t   c, h;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 15) begin
        r.org[i] = $urandom;
        r.dir[i] = rand_coord();
        r.lo[i]  = rand_coord();
        r.hi[i]  = rand_coord();
      end else begin
        c = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        h = $urandom_range(32'h0004_0000, 1);
        r.lo[i]  = c - h;
        r.hi[i]  = c + h;
        r.org[i] = c + ($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
        r.dir[i] = (c - r.org[i] + ($signed($urandom_range(32'hFFFF)) - 32'sh8000))
                   >>> $urandom_range(8);
        if (kind < 30) r.lo[i] = r.hi[i] + 1;  // swapped corners now and then
        if ($urandom_range(9) == 0) begin
          r.dir[i] = 0;
          if ($urandom_range(3) != 0) r.org[i] = c;
        end
      end
    end
    return r;
  endfunction

  function automatic ray_box_t mk(coord_t ox, coord_t oy, coord_t oz,
                                  coord_t dx, coord_t dy, coord_t dz,
                                  coord_t lx, coord_t ly, coord_t lz,
                                  coord_t hx, coord_t hy, coord_t hz);
    ray_box_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    r.lo  = '{lx, ly, lz};
    r.hi  = '{hx, hy, hz};
    return r;
  endfunction

  task automatic run_random(int tx_pct, int rx_pct, int n);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) send_ray(rand_ray());
  endtask

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t MAXC = 32'sh7FFF_FFFF;
  localparam coord_t MINC = 32'sh8000_0000;

  initial begin
    ray_box_t directed [$];
    cur_ray = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Hit along each axis: x from either side, y from below, z from above.
    directed.push_back(mk(-4*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    directed.push_back(mk(4*ONE, 0, 0, -ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    directed.push_back(mk(0, -4*ONE, 0, 0, 2*ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    directed.push_back(mk(0, 0, 5*ONE, 0, 0, -3*ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Diagonal into a corner: entry distances tie, first axis kept.
    directed.push_back(mk(-3*ONE, -3*ONE, 0, ONE, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    directed.push_back(mk(-3*ONE, -3*ONE, -3*ONE, ONE, ONE, ONE,
                          -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // All axes parallel, origin inside: still a miss.
    directed.push_back(mk(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Parallel axis with origin outside its slab.
    directed.push_back(mk(-4*ONE, 2*ONE, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Origin inside the box: entry distance negative.
    directed.push_back(mk(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Box behind the ray, and an interval that empties.
    directed.push_back(mk(4*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    directed.push_back(mk(-4*ONE, 4*ONE, 0, ONE, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Swapped corners on a moving axis and on a parallel one.
    directed.push_back(mk(-4*ONE, 0, 0, ONE, ONE, 0, ONE, ONE, -ONE, -ONE, -ONE, ONE));
    directed.push_back(mk(-4*ONE, 0, 0, ONE, 0, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
    // Tiny direction, far box: distance and points saturate.
    directed.push_back(mk(MINC, 0, 0, 1, 0, 0, MAXC - 1, MINC, MINC, MAXC, MAXC, MAXC));
    directed.push_back(mk(MINC, MINC, MINC, 1, 1, 1, 0, 0, 0, MAXC, MAXC, MAXC));
    directed.push_back(mk(MAXC, MAXC, MAXC, -1, -1, -1, MINC, MINC, MINC, 0, 0, 0));
    // Extreme direction and field values.
    directed.push_back(mk(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                          MAXC, MAXC, MAXC));
    directed.push_back(mk(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC,
                          MINC, MINC, MINC));
    directed.push_back(mk(MAXC, 0, 0, MINC, 0, 0, MINC, MINC, MINC, MAXC, MAXC, MAXC));
    directed.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    directed.push_back(mk(-2*ONE, -2*ONE, -2*ONE, 3, 5, 7, -ONE, -ONE, -ONE, ONE, ONE, ONE));

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    foreach (directed[i]) send_ray(directed[i]);

    run_random(22, 64, 150);
    run_random(64, 22, 150);
    // Long output hold-off while the input keeps offering items.
    hold_req <= 1;
    run_random(0, 0, 150);
    in_valid <= 0;

    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
